// ----- design/mec_pkg.sv -----
package mec_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS = 28;
  localparam int ITER_W = 12;
  localparam int COLOR_W = 8;
  // z after one update from an unchecked start point stays below 2^36 in magnitude
  localparam int Z_W = DATA_W + 6;
  localparam int PROD_W = 2 * DATA_W;
  localparam int Q_DEPTH = 2;
  localparam int DIV_W = 20;

  localparam logic [ITER_W-1:0] MAX_ITER_LIMIT = 12'd4095;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 12'd200;

  localparam logic [COLOR_W-1:0] RED_BASE = 8'd102;
  localparam logic [DIV_W-1:0] RED_COEF = 20'd153;
  localparam logic [DIV_W-1:0] GREEN_COEF = 20'd255;

  localparam int CFG_MAX_ITER = 0;

  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] iter;
    logic [ITER_W-1:0] limit;
  } class_t;

endpackage

// ----- design/mandelbrot_escape_color.sv -----
// channel  signals                                   transfer when
// in       in_valid, in_stall, c_real, c_imag        in_valid && !in_stall
// out      out_valid, out_stall, red, green, blue,   out_valid && !out_stall
//          escaped, escape_iter
// cfg      psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite && pready
//          prdata, pready
//
// front: each pass of the squaring loop is a multiply state, then an add and escape test state,
//   led by an accept state and followed by a hand-off state; a zero pass limit goes
//   straight from accept to hand-off
// back: an escaped point runs the two 8-step color divisions side by side; others skip them
// a 2-entry queue between them lets the front take a new point while a color waits
// out_stall holds the result register; in_stall is high while the front iterates
// rst is synchronous; the pass limit resets to 200
module mandelbrot_escape_color (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mec_pkg::DATA_W-1:0] c_real,
  input  logic signed [mec_pkg::DATA_W-1:0] c_imag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mec_pkg::COLOR_W-1:0]       red,
  output logic [mec_pkg::COLOR_W-1:0]       green,
  output logic [mec_pkg::COLOR_W-1:0]       blue,
  output logic                              escaped,
  output logic [mec_pkg::ITER_W-1:0]        escape_iter,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import mec_pkg::*;

  logic [ITER_W-1:0] pass_limit;
  logic cfg_sel;
  logic push, q_full, pop, q_empty;
  class_t push_data, pop_data;

  assign pready = 1'b1;
  assign cfg_sel = (paddr[2] == 1'(CFG_MAX_ITER));
  assign prdata = cfg_sel ? 32'(pass_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_limit <= MAX_ITER_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      pass_limit <= pwdata[ITER_W-1:0];
    end
  end

  mec_iter u_iter (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .c_real     (c_real),
    .c_imag     (c_imag),
    .pass_limit (pass_limit),
    .push       (push),
    .res        (push_data),
    .q_full     (q_full)
  );

  mec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mec_color u_color (
    .clk         (clk),
    .rst         (rst),
    .pop         (pop),
    .pop_data    (pop_data),
    .q_empty     (q_empty),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .escaped     (escaped),
    .escape_iter (escape_iter)
  );

endmodule

// ----- design/mec_iter.sv -----
module mec_iter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mec_pkg::DATA_W-1:0] c_real,
  input  logic signed [mec_pkg::DATA_W-1:0] c_imag,
  input  logic [mec_pkg::ITER_W-1:0]        pass_limit,
  output logic                              push,
  output mec_pkg::class_t                   res,
  input  logic                              q_full
);
  import mec_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_ADD  = 2'd2;
  localparam logic [1:0] F_DONE = 2'd3;

  localparam logic signed [Z_W-1:0] TWO = Z_W'(1) <<< (FRAC_BITS + 1);
  localparam logic signed [PROD_W-1:0] FOUR_SQ = PROD_W'(1) <<< (2 * FRAC_BITS + 2);

  logic [1:0] state;
  logic signed [Z_W-1:0] x, y;
  logic signed [DATA_W-1:0] cr, ci;
  logic signed [PROD_W-1:0] xx, yy, xy;
  logic big, first;
  logic [ITER_W-1:0] cnt, lim, lim_in;
  logic signed [DATA_W-1:0] xo, yo;
  logic signed [PROD_W-1:0] nx_w, ny_w;
  logic esc;

  assign in_stall = (state != F_IDLE);
  assign push = (state == F_DONE) && !q_full;

  assign lim_in = (pass_limit > MAX_ITER_LIMIT) ? MAX_ITER_LIMIT : pass_limit;

  // operands fit 32 bits unless out of range, and then big forces the escape in this pass
  assign xo = x[DATA_W-1:0];
  assign yo = y[DATA_W-1:0];

  assign nx_w = (xx >>> FRAC_BITS) - (yy >>> FRAC_BITS) + PROD_W'(cr);
  assign ny_w = (xy >>> (FRAC_BITS - 1)) + PROD_W'(ci);
  // the start point itself is never tested
  assign esc = !first && (big || ((xx + yy) > FOUR_SQ));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            x <= Z_W'(c_real);
            y <= Z_W'(c_imag);
            cr <= c_real;
            ci <= c_imag;
            cnt <= '0;
            first <= 1'b1;
            lim <= lim_in;
            if (lim_in == '0) begin
              res <= '{escaped: 1'b0, iter: '0, limit: lim_in};
              state <= F_DONE;
            end else begin
              state <= F_MUL;
            end
          end
        end
        F_MUL: begin
          xx <= xo * xo;
          yy <= yo * yo;
          xy <= xo * yo;
          big <= (x > TWO) || (x < -TWO) || (y > TWO) || (y < -TWO);
          state <= F_ADD;
        end
        F_ADD: begin
          if (esc) begin
            res <= '{escaped: 1'b1, iter: cnt - 1'b1, limit: lim};
            state <= F_DONE;
          end else if (cnt == lim) begin
            res <= '{escaped: 1'b0, iter: '0, limit: lim};
            state <= F_DONE;
          end else begin
            x <= nx_w[Z_W-1:0];
            y <= ny_w[Z_W-1:0];
            cnt <= cnt + 1'b1;
            first <= 1'b0;
            state <= F_MUL;
          end
        end
        F_DONE: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == F_MUL || state == F_ADD) |-> (cnt <= lim))
    else $error("pass count ran past the limit");
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (push && res.escaped) |-> (res.iter < res.limit))
    else $error("escape index not below limit");
`endif

endmodule

// ----- design/mec_fifo.sv -----
module mec_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mec_pkg::class_t push_data,
  output logic            full,
  input  logic            pop,
  output mec_pkg::class_t pop_data,
  output logic            empty
);
  import mec_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(Q_DEPTH - 1);

  class_t entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/mec_color.sv -----
module mec_color (
  input  logic                         clk,
  input  logic                         rst,
  output logic                         pop,
  input  mec_pkg::class_t              pop_data,
  input  logic                         q_empty,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mec_pkg::COLOR_W-1:0]  red,
  output logic [mec_pkg::COLOR_W-1:0]  green,
  output logic [mec_pkg::COLOR_W-1:0]  blue,
  output logic                         escaped,
  output logic [mec_pkg::ITER_W-1:0]   escape_iter
);
  import mec_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0] state;
  class_t ent;
  logic [2:0] k;
  logic [DIV_W-1:0] rem_r, rem_g, dv;
  logic [COLOR_W-1:0] q_r, q_g, q_r_next, q_g_next;
  logic [DIV_W-1:0] rem_r_next, rem_g_next;
  logic bit_r, bit_g;

  assign pop = (state == B_IDLE) && !q_empty;
  assign out_valid = (state == B_OUT);
  assign blue = '0;

  // restoring division, one quotient bit per cycle from the top; quotients stay below 255
  assign dv = DIV_W'(ent.limit) << k;
  assign bit_r = (rem_r >= dv);
  assign bit_g = (rem_g >= dv);
  assign rem_r_next = bit_r ? rem_r - dv : rem_r;
  assign rem_g_next = bit_g ? rem_g - dv : rem_g;
  assign q_r_next = {q_r[COLOR_W-2:0], bit_r};
  assign q_g_next = {q_g[COLOR_W-2:0], bit_g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            ent <= pop_data;
            if (pop_data.escaped) begin
              rem_r <= DIV_W'(pop_data.iter) * RED_COEF;
              rem_g <= DIV_W'(pop_data.iter) * GREEN_COEF;
              q_r <= '0;
              q_g <= '0;
              k <= 3'd7;
              state <= B_DIV;
            end else begin
              red <= '0;
              green <= '0;
              escaped <= 1'b0;
              escape_iter <= '0;
              state <= B_OUT;
            end
          end
        end
        B_DIV: begin
          rem_r <= rem_r_next;
          rem_g <= rem_g_next;
          q_r <= q_r_next;
          q_g <= q_g_next;
          if (k == '0) begin
            red <= RED_BASE + q_r_next;
            green <= q_g_next;
            escaped <= 1'b1;
            escape_iter <= ent.iter;
            state <= B_OUT;
          end else begin
            k <= k - 1'b1;
          end
        end
        B_OUT: begin
          if (!out_stall) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_escaped: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> ent.escaped)
    else $error("divider running on a point that did not escape");
  a_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !escaped) |-> (red == '0 && green == '0 && escape_iter == '0))
    else $error("non-escaped point not black");
`endif

endmodule

// ----- tb/mandelbrot_escape_color_tb.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_color_tb;
  import mec_pkg::*;

  localparam int Q1 = 1 << FRAC_BITS;
  localparam logic [2:0] ADDR_MAX_ITER = 3'(4 * CFG_MAX_ITER);
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               escaped;
    logic [ITER_W-1:0]  iter;
  } pixel_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [DATA_W-1:0]   c_real;
  logic signed [DATA_W-1:0]   c_imag;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [COLOR_W-1:0]         red;
  logic [COLOR_W-1:0]         green;
  logic [COLOR_W-1:0]         blue;
  logic                       escaped;
  logic [ITER_W-1:0]          escape_iter;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  pixel_t            pixel_q[$];
  pixel_t            want;
  logic [ITER_W-1:0] iter_limit;
  int                errors = 0;
  int                points_done = 0;
  int                escaped_cnt = 0;
  int                bounded_cnt = 0;
  int                settings_cnt = 0;
  int                idle_pct = 0;
  int                stall_left = 0;

  mandelbrot_escape_color dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .c_real(c_real),
    .c_imag(c_imag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .escaped(escaped),
    .escape_iter(escape_iter),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // escape-time iteration on exact wide products, floor on every shift
  function automatic pixel_t escape_color(input logic signed [DATA_W-1:0] cr,
                                          input logic signed [DATA_W-1:0] ci,
                                          input logic [ITER_W-1:0] lim);
    logic signed [127:0] x, y, nx, ny, cr_w, ci_w;
    logic [127:0]        ux, uy;
    pixel_t              px;
    bit                  hit;
    int unsigned         n;
    px = '0;
    cr_w = 128'(cr);
    ci_w = 128'(ci);
    x = cr_w;
    y = ci_w;
    n = 32'(lim);
    hit = 1'b0;
    for (int unsigned i = 0; i < n && !hit; i++) begin
      nx = ((x * x) >>> FRAC_BITS) - ((y * y) >>> FRAC_BITS) + cr_w;
      ny = ((x * y) >>> (FRAC_BITS - 1)) + ci_w;
      x = nx;
      y = ny;
      ux = (x < 0) ? -x : x;
      uy = (y < 0) ? -y : y;
      // strict test: |z|^2 == 4 stays inside
      if (ux > (128'd2 << FRAC_BITS) || uy > (128'd2 << FRAC_BITS) ||
          ux * ux + uy * uy > (128'd1 << (2 * FRAC_BITS + 2))) begin
        hit = 1'b1;
        px.escaped = 1'b1;
        px.iter = i[ITER_W-1:0];
        px.red = COLOR_W'((102 * n + 153 * i) / n);
        px.green = COLOR_W'((255 * i) / n);
      end
    end
    return px;
  endfunction

  task automatic send_point(input logic signed [DATA_W-1:0] cr,
                            input logic signed [DATA_W-1:0] ci);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    c_real = cr;
    c_imag = ci;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(escape_color(cr, ci, iter_limit));
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_valid = 1'b0;
    wait (pixel_q.size() == 0);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_MAX_ITER)
      iter_limit = data[ITER_W-1:0];
  endtask

  task automatic check_limit_readback;
    logic [31:0] got;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_MAX_ITER;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== 32'(iter_limit)) begin
      $error("pass limit readback: expected %0d, actual %0d", iter_limit, got);
      errors++;
    end
  endtask

  task automatic retune_limit(input logic [31:0] value);
    drain_results();
    apb_write(ADDR_MAX_ITER, value);
    check_limit_readback();
    settings_cnt++;
  endtask

  task automatic pick_point(output logic signed [DATA_W-1:0] cr,
                            output logic signed [DATA_W-1:0] ci);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      // mostly the neighborhood of the set, where passes run long
      cr = -2 * Q1 + int'($urandom_range(0, 5 * Q1 / 2));
      ci = int'($urandom_range(0, 644245094)) - 322122547;
    end else if (r < 85) begin
      cr = $urandom();
      ci = $urandom();
    end else begin
      case ($urandom_range(0, 9))
        0: cr = 0;
        1: cr = 1;
        2: cr = -1;
        3: cr = Q1;
        4: cr = -Q1;
        5: cr = 2 * Q1;
        6: cr = -2 * Q1;
        7: cr = 32'sh7FFF_FFFF;
        8: cr = 32'sh8000_0000;
        default: cr = Q1 / 4;
      endcase
      ci = ($urandom_range(0, 1) == 1) ? -cr : int'($urandom_range(0, Q1)) - Q1 / 2;
      if ($urandom_range(0, 1) == 1)
        {cr, ci} = {ci, cr};
    end
  endtask

  task automatic test_reset_limit;
    check_limit_readback();
  endtask

  task automatic test_directed_points;
    idle_pct = 30;
    send_point(0, 0);
    send_point(-2 * Q1, 0);
    send_point(2 * Q1, 0);
    send_point(0, 2 * Q1);
    send_point(Q1 / 4, 0);
    send_point(0, Q1);
    send_point(-Q1, 0);
    send_point(Q1, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(-3 * Q1 / 4, Q1 / 10);
    send_point(1, -1);
    send_point(Q1 / 4 + (1 << 16), 0);
  endtask

  task automatic test_limit_extremes;
    idle_pct = 0;
    retune_limit(32'd1);
    send_point(0, 0);
    send_point(Q1, 0);
    send_point(3 * Q1 / 2, 0);
    retune_limit(32'd0);
    send_point(2 * Q1, 0);
    send_point(0, 0);
    // upper bits of the write are dropped, leaving the largest limit
    retune_limit(32'hFFFF_FFFF);
    send_point(0, 0);
    send_point(Q1 / 4 + (1 << 12), 0);
    send_point(-3 * Q1 / 4, Q1 / 1000);
  endtask

  task automatic test_unmapped_write;
    logic signed [DATA_W-1:0] cr, ci;
    retune_limit(32'd37);
    apb_write(ADDR_UNMAPPED, 32'h0000_0FFF);
    check_limit_readback();
    idle_pct = 10;
    repeat (4) begin
      pick_point(cr, ci);
      send_point(cr, ci);
    end
  endtask

  task automatic test_random_points(input int total);
    int                       sent, phase_len, r;
    logic [ITER_W-1:0]        lim;
    logic signed [DATA_W-1:0] cr, ci;
    sent = 0;
    for (int phase = 0; sent < total; phase++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        lim = '0;
      else if (r < 10)
        lim = ITER_W'($urandom_range(1, 4));
      else if (r < 70)
        lim = ITER_W'($urandom_range(5, 64));
      else if (r < 95)
        lim = ITER_W'($urandom_range(65, 300));
      else
        lim = ITER_W'($urandom_range(301, 1500));
      retune_limit(($urandom() & 32'hFFFF_F000) | 32'(lim));
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      phase_len = $urandom_range(25, 60);
      for (int k = 0; k < phase_len && sent < total; k++) begin
        // hold off the sender until the pipeline is empty, then resume
        if (phase == 2 && k == phase_len / 2) begin
          drain_results();
          repeat (20) @(negedge clk);
        end
        pick_point(cr, ci);
        send_point(cr, ci);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("result transfer with no point pending");
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, red);
          errors++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, green);
          errors++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, blue);
          errors++;
        end
        if (escaped !== want.escaped) begin
          $error("escaped: expected %0d, actual %0d", want.escaped, escaped);
          errors++;
        end
        if (escape_iter !== want.iter) begin
          $error("escape_iter: expected %0d, actual %0d", want.iter, escape_iter);
          errors++;
        end
        points_done++;
        if (want.escaped)
          escaped_cnt++;
        else
          bounded_cnt++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    c_real = '0;
    c_imag = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    iter_limit = MAX_ITER_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_limit();
    test_directed_points();
    test_limit_extremes();
    test_unmapped_write();
    test_random_points(925);

    in_valid = 1'b0;
    wait (pixel_q.size() == 0);
    repeat (30) @(posedge clk);
    $display("%0d points checked across %0d pass limit settings", points_done, settings_cnt);
    $display("%0d escaped, %0d stayed bounded", escaped_cnt, bounded_cnt);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mec_pkg.sv
design/mec_iter.sv
design/mec_fifo.sv
design/mec_color.sv
design/mandelbrot_escape_color.sv
tb/mandelbrot_escape_color_tb.sv
